// ===== src/vefm_pkg.sv =====
// Shared types, constants and helpers of the voxel exposed-face mask unit.
`default_nettype none

package vefm_pkg;

  // Widths fixed by the register map and the result fields
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;
  localparam int HOLE_W    = 10;
  localparam int FACE_W    = 6;
  localparam int TOTAL_W   = 20;
  localparam int COORD_W   = 8;
  localparam int CNT_W     = 4;

  localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 9'd21;

  // Face bit positions inside a mask
  localparam int FACE_NZ = 0;
  localparam int FACE_PZ = 1;
  localparam int FACE_NX = 2;
  localparam int FACE_PX = 3;
  localparam int FACE_NY = 4;
  localparam int FACE_PY = 5;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE   = 3'd0,
    CFG_HOLE_ENABLE = 3'd1,
    CFG_HOLE_X0     = 3'd2,
    CFG_HOLE_Y0     = 3'd3,
    CFG_HOLE_WIDTH  = 3'd4,
    CFG_HOLE_HEIGHT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] grid_size;
    logic             hole_enable;
    logic [CFG_W-1:0] hole_x0;
    logic [CFG_W-1:0] hole_y0;
    logic [CFG_W-1:0] hole_width;
    logic [CFG_W-1:0] hole_height;
  } cfg_t;

  // Position class of one cell, worked out by the front end
  typedef struct packed {
    logic cur;     // raised bit after the hole cut
    logic first;   // first cell of a frame
    logic x_ge1;
    logic x_ge2;
    logic x_last;
    logic y_ge1;
    logic y_ge2;
    logic y_last;
  } cell_flags_t;

  function automatic logic [2:0] ones6(input logic [FACE_W-1:0] m);
    logic [2:0] c;
    c = '0;
    for (int i = 0; i < FACE_W; i++) c = c + 3'(m[i]);
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/vefm_front.sv =====
// Front end: raster counters, hole cut and cell classification.
`default_nettype none

module vefm_front #(
  parameter int MAX_SIZE = 256,
  localparam int CW = $clog2(MAX_SIZE)
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  vefm_pkg::cfg_t             cfg,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire                        in_module_bit,
  input  wire                        q_full,
  output logic                       q_push,
  output logic [CW-1:0]              d_x,
  output logic [CW-1:0]              d_y,
  output vefm_pkg::cell_flags_t      d_flags
);
  import vefm_pkg::*;

  localparam int NW = $clog2(MAX_SIZE + 1);
  localparam int GW = (NW > CFG_W) ? NW : CFG_W;

  logic [CW-1:0]     x_r, x_nxt, y_r, y_nxt;
  logic [CW-1:0]     nm1;
  logic [GW-1:0]     grid_w;
  logic              restart;
  logic [CW-1:0]     x, y;
  logic [HOLE_W-1:0] hole_x_end, hole_y_end;
  logic              in_hole;
  logic              accept;

  // Clamp the grid size and form its last index
  assign grid_w = GW'(cfg.grid_size);
  always_comb begin
    if (cfg.grid_size == '0) begin
      nm1 = '0;
    end else if (grid_w > GW'(MAX_SIZE)) begin
      nm1 = CW'(MAX_SIZE - 1);
    end else begin
      nm1 = CW'(grid_w - GW'(1));
    end
  end

  // Restart the frame when the counters fall outside a shrunken grid
  assign restart = (x_r > nm1) || (y_r > nm1);
  assign x       = restart ? '0 : x_r;
  assign y       = restart ? '0 : y_r;

  // Cut raised cells that lie in the hole rectangle
  assign hole_x_end = HOLE_W'(cfg.hole_x0) + HOLE_W'(cfg.hole_width);
  assign hole_y_end = HOLE_W'(cfg.hole_y0) + HOLE_W'(cfg.hole_height);
  assign in_hole = cfg.hole_enable
                && (HOLE_W'(x) >= HOLE_W'(cfg.hole_x0)) && (HOLE_W'(x) < hole_x_end)
                && (HOLE_W'(y) >= HOLE_W'(cfg.hole_y0)) && (HOLE_W'(y) < hole_y_end);

  // Classify the position
  always_comb begin
    d_flags.cur    = in_module_bit && !in_hole;
    d_flags.x_ge1  = (x != '0);
    d_flags.x_ge2  = (x != '0) && (x != CW'(1));
    d_flags.x_last = (x == nm1);
    d_flags.y_ge1  = (y != '0);
    d_flags.y_ge2  = (y != '0) && (y != CW'(1));
    d_flags.y_last = (y == nm1);
    d_flags.first  = (x == '0) && (y == '0);
  end

  assign d_x      = x;
  assign d_y      = y;
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  // Advance the raster position
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (accept) begin
      if (x == nm1) begin
        x_nxt = '0;
        y_nxt = (y == nm1) ? '0 : y + CW'(1);
      end else begin
        x_nxt = x + CW'(1);
        y_nxt = y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/vefm_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
`default_nettype none

module vefm_queue #(
  parameter int WIDTH = 8
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire [WIDTH-1:0]  wdata,
  output logic             full,
  input  wire              pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNTW'(DEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = slot_r[rp_r];

  // Move the pointers and the fill count
  always_comb begin
    wp_nxt  = push ? wp_r + AW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + AW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/vefm_back.sv =====
// Back end: line buffer, neighbor window, face masks, running total and result register.
`default_nettype none

module vefm_back #(
  parameter int MAX_SIZE = 256,
  localparam int CW = $clog2(MAX_SIZE)
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             q_valid,
  output logic                            q_pop,
  input  wire [CW-1:0]                    q_x,
  input  wire [CW-1:0]                    q_y,
  input  vefm_pkg::cell_flags_t           q_flags,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [vefm_pkg::COORD_W-1:0]    out_cell_x,
  output logic [vefm_pkg::COORD_W-1:0]    out_cell_y,
  output logic [vefm_pkg::FACE_W-1:0]     out_base_faces,
  output logic [vefm_pkg::FACE_W-1:0]     out_raised_faces,
  output logic [vefm_pkg::TOTAL_W-1:0]    out_face_total,
  output logic                            out_last_of_run,
  output logic                            out_last_of_frame
);
  import vefm_pkg::*;

  // Result slots of one cell: row above, left neighbor on the last row, final cell
  localparam int SLOT_A = 0;
  localparam int SLOT_B = 1;
  localparam int SLOT_C = 2;

  // Line buffer word: bit 1 previous row, bit 0 the row before it
  logic [1:0]         lbuf [MAX_SIZE];
  logic [1:0]         rd0_r;
  logic               rd1_r;
  logic               byp0_r, byp1_r;
  logic [1:0]         byp_d_r;
  logic [CW-1:0]      rd_a1;

  logic               e_valid_r, e_valid_nxt;
  logic [CW-1:0]      e_x_r, e_y_r;
  cell_flags_t        e_f_r;
  logic [2:0]         pend_r, pend_nxt;
  logic [TOTAL_W-1:0] running_r, running_nxt;
  logic               prior_r, cur_d1_r, cur_d2_r;

  logic               mid, old, right_raw;
  logic               o_valid_r;
  logic               o_free, emit, retire, load;
  logic [2:0]         sel, pend_left;

  logic [CW-1:0]      cx, cy;
  logic               self_b, left_b, right_b, up_b, down_b;
  logic               nx_b, px_b, ny_b, py_b;
  logic [FACE_W-1:0]  base_m, raised_m;
  logic [CNT_W-1:0]   face_cnt;
  logic [TOTAL_W-1:0] total_sum;

  // Window bits, taking the bypass when the read met a write to the same entry
  assign mid       = byp0_r ? byp_d_r[1] : rd0_r[1];
  assign old       = byp0_r ? byp_d_r[0] : rd0_r[0];
  assign right_raw = byp1_r ? byp_d_r[1] : rd1_r;

  // Handshake between the cell register and the result register
  assign o_free    = !o_valid_r || !out_stall;
  assign emit      = e_valid_r && (pend_r != '0) && o_free;
  always_comb begin
    if (pend_r[SLOT_A]) begin
      sel = 3'b001;
    end else if (pend_r[SLOT_B]) begin
      sel = 3'b010;
    end else begin
      sel = 3'b100;
    end
  end
  assign pend_left = pend_r & ~sel;
  assign retire    = e_valid_r && ((pend_r == '0) || (emit && (pend_left == '0)));
  assign load      = q_valid && (!e_valid_r || retire);
  assign q_pop     = load;
  assign rd_a1     = (q_x == CW'(MAX_SIZE - 1)) ? '0 : q_x + CW'(1);

  // Gather coordinates and neighbors of the selected slot
  always_comb begin
    cx      = e_x_r;
    cy      = e_y_r;
    self_b  = e_f_r.cur;
    left_b  = e_f_r.x_ge1 && cur_d1_r;
    right_b = 1'b0;
    up_b    = e_f_r.y_ge1 && mid;
    down_b  = 1'b0;
    nx_b    = !e_f_r.x_ge1;
    px_b    = 1'b1;
    ny_b    = !e_f_r.y_ge1;
    py_b    = 1'b1;
    if (sel[SLOT_A]) begin
      cy      = e_y_r - CW'(1);
      self_b  = mid;
      left_b  = e_f_r.x_ge1 && prior_r;
      right_b = !e_f_r.x_last && right_raw;
      up_b    = e_f_r.y_ge2 && old;
      down_b  = e_f_r.cur;
      px_b    = e_f_r.x_last;
      ny_b    = !e_f_r.y_ge2;
      py_b    = 1'b0;
    end else if (sel[SLOT_B]) begin
      cx      = e_x_r - CW'(1);
      self_b  = cur_d1_r;
      left_b  = e_f_r.x_ge2 && cur_d2_r;
      right_b = e_f_r.cur;
      up_b    = e_f_r.y_ge1 && prior_r;
      nx_b    = !e_f_r.x_ge2;
      px_b    = 1'b0;
    end
  end

  // Build both face masks and count them
  always_comb begin
    base_m          = '0;
    base_m[FACE_NZ] = 1'b1;
    base_m[FACE_PZ] = !self_b;
    base_m[FACE_NX] = nx_b;
    base_m[FACE_PX] = px_b;
    base_m[FACE_NY] = ny_b;
    base_m[FACE_PY] = py_b;
    raised_m        = '0;
    if (self_b) begin
      raised_m[FACE_PZ] = 1'b1;
      raised_m[FACE_NX] = !left_b;
      raised_m[FACE_PX] = !right_b;
      raised_m[FACE_NY] = !up_b;
      raised_m[FACE_PY] = !down_b;
    end
  end
  assign face_cnt  = CNT_W'(ones6(base_m)) + CNT_W'(ones6(raised_m));
  assign total_sum = running_r + TOTAL_W'(face_cnt);

  // Next cell register state
  always_comb begin
    e_valid_nxt = e_valid_r;
    pend_nxt    = pend_r;
    running_nxt = running_r;
    if (emit) begin
      pend_nxt    = pend_left;
      running_nxt = total_sum;
    end
    if (retire) begin
      e_valid_nxt = 1'b0;
    end
    if (load) begin
      e_valid_nxt      = 1'b1;
      pend_nxt[SLOT_A] = q_flags.y_ge1;
      pend_nxt[SLOT_B] = q_flags.y_last && q_flags.x_ge1;
      pend_nxt[SLOT_C] = q_flags.y_last && q_flags.x_last;
      if (q_flags.first) begin
        running_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
      pend_r    <= '0;
      running_r <= '0;
      o_valid_r <= 1'b0;
    end else begin
      e_valid_r <= e_valid_nxt;
      pend_r    <= pend_nxt;
      running_r <= running_nxt;
      if (emit) begin
        o_valid_r <= 1'b1;
      end else if (!out_stall) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  // Load the cell and its bypass flags
  always_ff @(posedge clk) begin
    if (load) begin
      e_x_r   <= q_x;
      e_y_r   <= q_y;
      e_f_r   <= q_flags;
      byp0_r  <= retire && (e_x_r == q_x);
      byp1_r  <= retire && (e_x_r == rd_a1);
      byp_d_r <= {e_f_r.cur, mid};
    end
  end

  // Shift the same-row history when a cell retires
  always_ff @(posedge clk) begin
    if (retire) begin
      prior_r  <= mid;
      cur_d1_r <= e_f_r.cur;
      cur_d2_r <= cur_d1_r;
    end
  end

  // Line buffer: write on retire, read both window entries on load
  always_ff @(posedge clk) begin
    if (retire) begin
      lbuf[e_x_r] <= {e_f_r.cur, mid};
    end
    if (load) begin
      rd0_r <= lbuf[q_x];
      rd1_r <= lbuf[rd_a1][1];
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (emit) begin
      out_cell_x        <= COORD_W'(cx);
      out_cell_y        <= COORD_W'(cy);
      out_base_faces    <= base_m;
      out_raised_faces  <= raised_m;
      out_face_total    <= total_sum;
      out_last_of_run   <= (pend_left == '0);
      out_last_of_frame <= sel[SLOT_C];
    end
  end

  assign out_valid = o_valid_r;

endmodule

`default_nettype wire

// ===== src/voxel_exposed_face_mask_unit.sv =====
// Top level of the voxel exposed-face mask unit: register file and front/back assembly.
//
// Module bits arrive on in_valid/in_stall/in_module_bit in raster order over a
// grid_size x grid_size grid. Each accepted item is classified in the front end
// (position, hole cut) and handed through a two-entry queue to the back end,
// which keeps a two-row line buffer and emits one result per cycle on
// out_valid/out_stall while out_stall is low: the cell of the row above, and on
// the last row also the left neighbor and the final cell of the frame.
// Throughput: one item per cycle on all rows but the last while out_stall is low;
// on the last row each item after the first yields two results (three for the
// final cell) and the single result port sets the pace. Row 0 gives no results
// unless it is also the last row. Configuration is written on cfg_valid/cfg_ready
// (always ready) by index; the user must write it only while the unit is idle, and
// the block has no check for that. Reset restores the register defaults and
// restarts the frame at (0,0); the line buffer needs no clearing since each row is
// written before it is read. When out_stall is high the result register holds, the
// queue fills and in_stall rises once the queue is full.
`default_nettype none

module voxel_exposed_face_mask_unit #(
  parameter int MAX_SIZE = 256,
  localparam int CW = $clog2(MAX_SIZE)
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [vefm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [vefm_pkg::CFG_W-1:0]       cfg_data,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire                             in_module_bit,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [vefm_pkg::COORD_W-1:0]    out_cell_x,
  output logic [vefm_pkg::COORD_W-1:0]    out_cell_y,
  output logic [vefm_pkg::FACE_W-1:0]     out_base_faces,
  output logic [vefm_pkg::FACE_W-1:0]     out_raised_faces,
  output logic [vefm_pkg::TOTAL_W-1:0]    out_face_total,
  output logic                            out_last_of_run,
  output logic                            out_last_of_frame
);
  import vefm_pkg::*;

  localparam int DESC_W = 2 * CW + $bits(cell_flags_t);

  cfg_t          cfg_r, cfg_nxt;
  logic          q_push, q_full, q_pop, q_valid;
  logic [CW-1:0] f_x, f_y, b_x, b_y;
  cell_flags_t   f_flags, b_flags;
  logic [DESC_W-1:0] q_wdata, q_rdata;

  // Register writes
  assign cfg_ready = 1'b1;
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRID_SIZE:   cfg_nxt.grid_size   = cfg_data;
        CFG_HOLE_ENABLE: cfg_nxt.hole_enable = cfg_data[0];
        CFG_HOLE_X0:     cfg_nxt.hole_x0     = cfg_data;
        CFG_HOLE_Y0:     cfg_nxt.hole_y0     = cfg_data;
        CFG_HOLE_WIDTH:  cfg_nxt.hole_width  = cfg_data;
        CFG_HOLE_HEIGHT: cfg_nxt.hole_height = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_size   <= GRID_SIZE_RESET;
      cfg_r.hole_enable <= 1'b0;
      cfg_r.hole_x0     <= '0;
      cfg_r.hole_y0     <= '0;
      cfg_r.hole_width  <= '0;
      cfg_r.hole_height <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  vefm_front #(.MAX_SIZE(MAX_SIZE)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_module_bit (in_module_bit),
    .q_full        (q_full),
    .q_push        (q_push),
    .d_x           (f_x),
    .d_y           (f_y),
    .d_flags       (f_flags)
  );

  // Pack and unpack the queue entry
  assign q_wdata = {f_x, f_y, f_flags};
  assign {b_x, b_y, b_flags} = q_rdata;

  vefm_queue #(.WIDTH(DESC_W)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  vefm_back #(.MAX_SIZE(MAX_SIZE)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_x               (b_x),
    .q_y               (b_y),
    .q_flags           (b_flags),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cell_x        (out_cell_x),
    .out_cell_y        (out_cell_y),
    .out_base_faces    (out_base_faces),
    .out_raised_faces  (out_raised_faces),
    .out_face_total    (out_face_total),
    .out_last_of_run   (out_last_of_run),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

`default_nettype wire

// ===== tb/voxel_exposed_face_mask_unit_tb.sv =====
// Self-checking testbench for the voxel exposed-face mask unit: random raster streams vs a cell predictor.
`timescale 1ns / 100ps

module voxel_exposed_face_mask_unit_tb;
  import vefm_pkg::*;

  localparam int GRID_MAX    = 256;
  localparam int PRESS_SIDE  = 8;
  localparam int LONG_HOLD   = 120;
  localparam int SETTLE      = 8;
  localparam int RANDOM_BITS = 150;
  localparam int PRINT_CAP   = 100;

  typedef struct {
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [FACE_W-1:0]  base_faces;
    logic [FACE_W-1:0]  raised_faces;
    logic [TOTAL_W-1:0] face_total;
    logic               last_of_run;
    logic               last_of_frame;
  } face_cell_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_module_bit = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COORD_W-1:0]   out_cell_x;
  logic [COORD_W-1:0]   out_cell_y;
  logic [FACE_W-1:0]    out_base_faces;
  logic [FACE_W-1:0]    out_raised_faces;
  logic [TOTAL_W-1:0]   out_face_total;
  logic                 out_last_of_run;
  logic                 out_last_of_frame;

  // Pending module bits and predicted cell results
  bit         module_bits[$];
  face_cell_t expected_cells[$];

  // Predictor state: register copy, two line buffers, raster position
  cfg_t               shadow_cfg;
  bit                 last_row_bits[GRID_MAX];
  bit                 older_row_bits[GRID_MAX];
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;
  bit                 left_prior = 1'b0;
  bit [TOTAL_W-1:0]   face_sum = '0;

  bit idle_on = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int items_accepted = 0;
  int cells_checked = 0;
  int mismatch_count = 0;
  int reg_writes = 0;

  voxel_exposed_face_mask_unit #(.MAX_SIZE(GRID_MAX)) DUT (.*);

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int unsigned grid_side();
    int unsigned n;
    n = shadow_cfg.grid_size;
    if (n == 0) n = 1;
    if (n > GRID_MAX) n = GRID_MAX;
    return n;
  endfunction

  // Items left until the current frame closes, counting a pending restart
  function automatic int unsigned to_frame_end();
    int unsigned n;
    n = grid_side();
    if (col_pos >= n || row_pos >= n) return n * n;
    return n * n - (row_pos * n + col_pos);
  endfunction

  // Growing the grid mid-frame would read line buffer entries never written
  function automatic bit size_change_safe(int unsigned side);
    return side <= grid_side() || (col_pos == 0 && row_pos == 0) ||
           col_pos >= side || row_pos >= side;
  endfunction

  function automatic int unsigned hole_pick(int unsigned side);
    if ($urandom_range(0, 7) == 0) return GRID_MAX;
    return $urandom_range(0, side);
  endfunction

  function automatic face_cell_t make_cell(int unsigned n, int unsigned x, int unsigned y,
      bit filled, bit left, bit right, bit up, bit down, bit frame_end);
    face_cell_t c;
    logic [FACE_W-1:0] base;
    logic [FACE_W-1:0] raised;
    base = '0;
    raised = '0;
    base[FACE_NZ] = 1'b1;
    base[FACE_PZ] = !filled;
    base[FACE_NX] = (x == 0);
    base[FACE_PX] = (x == n - 1);
    base[FACE_NY] = (y == 0);
    base[FACE_PY] = (y == n - 1);
    if (filled) begin
      raised[FACE_PZ] = 1'b1;
      raised[FACE_NX] = !left;
      raised[FACE_PX] = !right;
      raised[FACE_NY] = !up;
      raised[FACE_PY] = !down;
    end
    face_sum = face_sum + TOTAL_W'($countones(base) + $countones(raised));
    c.cell_x        = x[COORD_W-1:0];
    c.cell_y        = y[COORD_W-1:0];
    c.base_faces    = base;
    c.raised_faces  = raised;
    c.face_total    = face_sum;
    c.last_of_run   = 1'b0;
    c.last_of_frame = frame_end;
    return c;
  endfunction

  // Advance the raster by one module bit and queue the cells it completes
  task automatic predict_cells(input bit module_bit);
    int unsigned n;
    int unsigned x;
    int unsigned y;
    int unsigned cx;
    bit cur;
    bit mid;
    bit old;
    face_cell_t cells[3];
    int k;
    n = grid_side();
    k = 0;
    if (col_pos >= n || row_pos >= n) begin
      col_pos = 0;
      row_pos = 0;
      face_sum = '0;
    end
    x = col_pos;
    y = row_pos;
    cur = module_bit;
    // drop raised modules under the hole
    if (shadow_cfg.hole_enable && x >= shadow_cfg.hole_x0 &&
        x < int'(shadow_cfg.hole_x0) + int'(shadow_cfg.hole_width) &&
        y >= shadow_cfg.hole_y0 &&
        y < int'(shadow_cfg.hole_y0) + int'(shadow_cfg.hole_height)) begin
      cur = 1'b0;
    end
    old = older_row_bits[x];
    mid = last_row_bits[x];
    older_row_bits[x] = mid;
    last_row_bits[x] = cur;
    // cell of the row above
    if (y >= 1) begin
      cells[k] = make_cell(n, x, y - 1, mid, (x >= 1) ? left_prior : 1'b0,
                           (x + 1 < n) ? last_row_bits[x + 1] : 1'b0,
                           (y >= 2) ? old : 1'b0, cur, 1'b0);
      k++;
    end
    left_prior = mid;
    // flush the last row as it arrives
    if (y == n - 1) begin
      if (x >= 1) begin
        cx = x - 1;
        cells[k] = make_cell(n, cx, y, last_row_bits[cx],
                             (cx >= 1) ? last_row_bits[cx - 1] : 1'b0, cur,
                             (y >= 1) ? older_row_bits[cx] : 1'b0, 1'b0, 1'b0);
        k++;
      end
      if (x == n - 1) begin
        cells[k] = make_cell(n, x, y, cur, (x >= 1) ? last_row_bits[x - 1] : 1'b0, 1'b0,
                             (y >= 1) ? older_row_bits[x] : 1'b0, 1'b0, 1'b1);
        k++;
      end
    end
    if (k > 0) cells[k - 1].last_of_run = 1'b1;
    for (int i = 0; i < k; i++) expected_cells.push_back(cells[i]);
    col_pos = x + 1;
    if (col_pos >= n) begin
      col_pos = 0;
      row_pos = y + 1;
      if (row_pos >= n) begin
        row_pos = 0;
        face_sum = '0;
      end
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want_val);
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want_val);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input face_cell_t w, input string name, input logic [31:0] got,
                             input logic [31:0] want_val);
    if (got !== want_val) begin
      note_mismatch($sformatf("cell (%0d,%0d) %s", w.cell_x, w.cell_y, name), got, want_val);
    end
  endtask

  task automatic check_cell();
    face_cell_t want;
    if (expected_cells.size() == 0) begin
      note_mismatch($sformatf("unexpected result for cell (%0d,%0d)", out_cell_x, out_cell_y),
                    1, 0);
      return;
    end
    want = expected_cells.pop_front();
    cells_checked++;
    check_field(want, "cell_x", out_cell_x, want.cell_x);
    check_field(want, "cell_y", out_cell_y, want.cell_y);
    check_field(want, "base_faces", out_base_faces, want.base_faces);
    check_field(want, "raised_faces", out_raised_faces, want.raised_faces);
    check_field(want, "face_total", out_face_total, want.face_total);
    check_field(want, "last_of_run", out_last_of_run, want.last_of_run);
    check_field(want, "last_of_frame", out_last_of_frame, want.last_of_frame);
  endtask

  // Input driver: offer queued bits, predict on acceptance, insert random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_cells(in_module_bit);
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (module_bits.size() > 0) begin
          in_valid <= 1'b1;
          in_module_bit <= module_bits.pop_front();
          gap_left <= idle_on ? idle_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check accepted cells, stall at random or for a long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) check_cell();
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (holds_served != hold_requests) begin
        holds_served <= holds_served + 1;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (idle_on && $urandom_range(0, 3) == 0) stall_left <= idle_len();
      end
    end
  end

  task automatic set_reg(input cfg_idx_t idx, input int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_GRID_SIZE:   shadow_cfg.grid_size   = value[CFG_W-1:0];
      CFG_HOLE_ENABLE: shadow_cfg.hole_enable = value[0];
      CFG_HOLE_X0:     shadow_cfg.hole_x0     = value[CFG_W-1:0];
      CFG_HOLE_Y0:     shadow_cfg.hole_y0     = value[CFG_W-1:0];
      CFG_HOLE_WIDTH:  shadow_cfg.hole_width  = value[CFG_W-1:0];
      CFG_HOLE_HEIGHT: shadow_cfg.hole_height = value[CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_pattern(input bit [31:0] pattern, input int count);
    @(negedge clk);
    for (int i = 0; i < count; i++) module_bits.push_back(pattern[i]);
  endtask

  task automatic queue_bits(input int unsigned count, input int unsigned density);
    @(negedge clk);
    for (int unsigned i = 0; i < count; i++) begin
      module_bits.push_back($urandom_range(0, 99) < density);
    end
  endtask

  // Wait until every bit is in and every cell is out, then let the pipe settle
  task automatic wait_drained();
    int spin;
    spin = 0;
    while ((module_bits.size() != 0 || in_valid || expected_cells.size() != 0) &&
           spin < 20000) begin
      @(negedge clk);
      spin++;
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int unsigned new_side;
    int unsigned count;
    int unsigned density;
    int unsigned phase_no;
    int unsigned random_items;
    shadow_cfg = '0;
    shadow_cfg.grid_size = GRID_SIZE_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // one-cell grid, size written as zero
    set_reg(CFG_GRID_SIZE, 0);
    queue_pattern(32'b01, 2);
    wait_drained();

    // 3x3 all dark with the center cut out by the hole
    set_reg(CFG_GRID_SIZE, 3);
    set_reg(CFG_HOLE_ENABLE, 1);
    set_reg(CFG_HOLE_X0, 1);
    set_reg(CFG_HOLE_Y0, 1);
    set_reg(CFG_HOLE_WIDTH, 1);
    set_reg(CFG_HOLE_HEIGHT, 1);
    queue_pattern(32'h1FF, 9);
    wait_drained();

    // 2x2 grid: the final item yields three cells
    set_reg(CFG_HOLE_ENABLE, 0);
    set_reg(CFG_GRID_SIZE, 2);
    queue_pattern(32'b1001, 4);
    wait_drained();

    // shrink mid-frame with the position outside the new grid: frame restarts
    set_reg(CFG_GRID_SIZE, 4);
    queue_pattern(32'b101101, 6);
    wait_drained();
    set_reg(CFG_GRID_SIZE, 2);
    queue_pattern(32'b0110, 4);
    wait_drained();

    // full mid-size frame, hole over the right edge; long result hold near the end
    idle_on = 1'b1;
    set_reg(CFG_GRID_SIZE, PRESS_SIDE);
    set_reg(CFG_HOLE_ENABLE, 1);
    set_reg(CFG_HOLE_X0, PRESS_SIDE - 2);
    set_reg(CFG_HOLE_Y0, 1);
    set_reg(CFG_HOLE_WIDTH, GRID_MAX);
    set_reg(CFG_HOLE_HEIGHT, GRID_MAX);
    queue_bits(PRESS_SIDE * PRESS_SIDE, 50);
    while (module_bits.size() > 2 * PRESS_SIDE) @(negedge clk);
    hold_requests++;
    wait_drained();

    // oversize grid value saturates to the widest side
    set_reg(CFG_GRID_SIZE, 9'h1FF);
    queue_bits(5, 50);
    wait_drained();

    // random frames with random holes and partial tails
    phase_no = 0;
    random_items = 0;
    while (random_items < RANDOM_BITS) begin
      new_side = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 12);
      // finish the running frame before growing the grid
      if (!size_change_safe(new_side)) begin
        count = to_frame_end();
        queue_bits(count, 50);
        random_items += count;
        wait_drained();
      end
      set_reg(CFG_GRID_SIZE, (new_side == 1 && $urandom_range(0, 1) == 1) ? 0 : new_side);
      set_reg(CFG_HOLE_ENABLE, $urandom_range(0, 1));
      set_reg(CFG_HOLE_X0, hole_pick(new_side));
      set_reg(CFG_HOLE_Y0, hole_pick(new_side));
      set_reg(CFG_HOLE_WIDTH, hole_pick(new_side));
      set_reg(CFG_HOLE_HEIGHT, hole_pick(new_side));
      idle_on = ($urandom_range(0, 3) != 0);
      count = to_frame_end() + $urandom_range(0, 2 * new_side);
      if (new_side <= 4) count += new_side * new_side;
      density = $urandom_range(10, 90);
      queue_bits(count, density);
      random_items += count;
      // hold results back while the last rows stream in
      if (phase_no % 4 == 1) begin
        while (module_bits.size() > new_side) @(negedge clk);
        hold_requests++;
      end
      wait_drained();
      phase_no++;
    end

    wait_drained();
    if (expected_cells.size() != 0) begin
      note_mismatch("cells never produced", 0, expected_cells.size());
    end
    $display("Covered %0d module bits and %0d register writes over %0d random frames,",
             items_accepted, reg_writes, phase_no);
    $display("grid sides 1 to 12 plus saturation, hole cuts and restarts; %0d cells checked.",
             cells_checked);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #(8_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
src/vefm_pkg.sv
src/vefm_front.sv
src/vefm_queue.sv
src/vefm_back.sv
src/voxel_exposed_face_mask_unit.sv
tb/voxel_exposed_face_mask_unit_tb.sv
